[hw/rtl/assert_macros.svh]
// assertion macros for the rtl of the tape machine executor
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_NR(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/tmbe_pkg.sv]
// package of the tape machine executor: widths, opcodes, status codes,
// controller/datapath interface structs and elaboration helpers
// no dependencies
package tmbe_pkg;

	localparam int TAPE_DEPTH_DEF = 32768;
	localparam int PROG_DEPTH_DEF = 65536;

	localparam int MODE_W  = 4;
	localparam int BYTE_W  = 8;
	localparam int OFS_W   = 17;
	localparam int MAG_W   = 17;
	localparam int NPC_W   = 16;
	localparam int STAT_W  = 3;
	localparam int RED_K_W = 5;
	localparam longint MAG_MAX = 65536;

	localparam logic [MODE_W-1:0] OP_EMPTY = 4'd0;
	localparam logic [MODE_W-1:0] OP_ADD   = 4'd1;
	localparam logic [MODE_W-1:0] OP_SET   = 4'd2;
	localparam logic [MODE_W-1:0] OP_MUL   = 4'd3;
	localparam logic [MODE_W-1:0] OP_SCAN  = 4'd4;
	localparam logic [MODE_W-1:0] OP_MOVE  = 4'd5;
	localparam logic [MODE_W-1:0] OP_JZ    = 4'd6;
	localparam logic [MODE_W-1:0] OP_JNZ   = 4'd7;
	localparam logic [MODE_W-1:0] OP_IO    = 4'd8;
	localparam logic [MODE_W-1:0] OP_HALT  = 4'd9;

	localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
	localparam logic [STAT_W-1:0] ST_HALT   = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
	localparam logic [STAT_W-1:0] ST_BADOP  = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOZERO = 3'd4;

	typedef struct packed {
		logic take;
		logic red_step;
		logic clr_step;
		logic mul_rd;
		logic scan_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic in_red;
		logic red_last;
		logic clr_last;
		logic op_mul;
		logic op_scan;
		logic scan_end;
		logic slot_ok;
	} stat_t;

	// compare-subtract steps needed to bring an offset magnitude below d
	function automatic int red_steps(longint d);
		longint dd;
		int s;
		s = 0;
		dd = d;
		if ((d & (d - 1)) == 0)
			return 0;
		while (dd <= MAG_MAX) begin
			dd = dd << 1;
			s++;
		end
		return s;
	endfunction

	function automatic int max_int(int a, int b);
		return (a > b) ? a : b;
	endfunction

endpackage

[hw/rtl/tape_machine_bitcode_executor_top.sv]
// Executes one tape-machine instruction per transaction against a byte tape
// held in a single-port-read ram. After reset the tape is swept to zero, one
// cell a cycle, and no instruction is taken meanwhile. Add, set, move, jumps,
// io, halt and the empty or invalid codes are accepted and then executed;
// multiply adds a second tape read for the target cell; a scan reads one cell
// per cycle on the tape read port until it finds a zero or has visited all
// TAPE_DEPTH cells. Where a depth is not a power of two, instructions that use
// the offset first pass through compare-subtract reduction steps (none at the
// default depths). A finished result sits in an output register, so a stalled
// result only holds the block in its final step.
// depends on tmbe_pkg, tmbe_ctrl, tmbe_dp, tmbe_ram, assert_macros.svh
`include "assert_macros.svh"

module tape_machine_bitcode_executor_top #(
	parameter int TAPE_DEPTH = tmbe_pkg::TAPE_DEPTH_DEF,
	parameter int PROG_DEPTH = tmbe_pkg::PROG_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               instr_valid,
	output logic                               instr_stall,
	input  logic [tmbe_pkg::MODE_W-1:0]        mode,
	input  logic [tmbe_pkg::BYTE_W-1:0]        value,
	input  logic signed [tmbe_pkg::OFS_W-1:0]  offset,
	input  logic [tmbe_pkg::BYTE_W-1:0]        in_byte,
	input  logic                               in_eof,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [tmbe_pkg::NPC_W-1:0]         next_pc,
	output logic                               out_valid,
	output logic [tmbe_pkg::BYTE_W-1:0]        out_byte,
	output logic [tmbe_pkg::STAT_W-1:0]        status
);
	import tmbe_pkg::*;

	cmd_t  cmd;
	stat_t st;

	tmbe_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_stall (instr_stall),
		.st          (st),
		.cmd         (cmd)
	);

	tmbe_dp #(
		.TAPE_DEPTH(TAPE_DEPTH),
		.PROG_DEPTH(PROG_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode),
		.value        (value),
		.offset       (offset),
		.in_byte      (in_byte),
		.in_eof       (in_eof),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.next_pc      (next_pc),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.status       (status),
		.cmd          (cmd),
		.st           (st)
	);

	// no transaction accepted during the clearing sweep
	`ASSERT_CLK_NR(a_clr_stall, clk, cmd.clr_step |-> instr_stall, "accept during tape clear")
	// a result is never written over one still waiting
	`ASSERT_CLK(a_no_overwrite, clk, arst_n, cmd.finish |-> (!result_valid || !result_stall), "result overwritten")
	`ASSERT_CLK(a_finish_shows, clk, arst_n, cmd.finish |=> result_valid, "finished result not presented")
	// one instruction in flight at a time
	`ASSERT_CLK(a_take_single, clk, arst_n, cmd.take |=> !cmd.take, "instruction taken while busy")

endmodule

[hw/rtl/tmbe_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module tmbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/tmbe_ctrl.sv]
// controller of the tape machine executor: clearing pass, offset reduction,
// execute, scan and multiply sequencing; depends on tmbe_pkg
module tmbe_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            instr_valid,
	output logic            instr_stall,
	input  tmbe_pkg::stat_t st,
	output tmbe_pkg::cmd_t  cmd
);
	import tmbe_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RED  = 3'd2;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_MULW = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_n;

	always_comb begin
		cmd = '0;
		state_n = state_q;
		instr_stall = 1'b1;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last)
					state_n = S_IDLE;
			end
			S_IDLE: begin
				instr_stall = 1'b0;
				if (instr_valid) begin
					cmd.take = 1'b1;
					state_n = st.in_red ? S_RED : S_EXEC;
				end
			end
			S_RED: begin
				cmd.red_step = 1'b1;
				if (st.red_last)
					state_n = S_EXEC;
			end
			S_EXEC: begin
				priority if (st.op_mul) begin
					cmd.mul_rd = 1'b1;
					state_n = S_MULW;
				end else if (st.op_scan && !st.scan_end) begin
					cmd.scan_step = 1'b1;
					state_n = S_SCAN;
				end else if (st.slot_ok) begin
					cmd.finish = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_SCAN: begin
				priority if (!st.scan_end) begin
					cmd.scan_step = 1'b1;
				end else if (st.slot_ok) begin
					cmd.finish = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_MULW: begin
				if (st.slot_ok) begin
					cmd.finish = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLR;
		else
			state_q <= state_n;
	end

endmodule

[hw/rtl/tmbe_dp.sv]
// datapath of the tape machine executor: tape ram, pointer and pc registers,
// offset reducer, scan walker and result register; depends on tmbe_pkg, tmbe_ram
module tmbe_dp #(
	parameter int TAPE_DEPTH = tmbe_pkg::TAPE_DEPTH_DEF,
	parameter int PROG_DEPTH = tmbe_pkg::PROG_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [tmbe_pkg::MODE_W-1:0]        mode,
	input  logic [tmbe_pkg::BYTE_W-1:0]        value,
	input  logic signed [tmbe_pkg::OFS_W-1:0]  offset,
	input  logic [tmbe_pkg::BYTE_W-1:0]        in_byte,
	input  logic                               in_eof,
	input  logic                               result_stall,
	output logic                               result_valid,
	output logic [tmbe_pkg::NPC_W-1:0]         next_pc,
	output logic                               out_valid,
	output logic [tmbe_pkg::BYTE_W-1:0]        out_byte,
	output logic [tmbe_pkg::STAT_W-1:0]        status,
	input  tmbe_pkg::cmd_t                     cmd,
	output tmbe_pkg::stat_t                    st
);
	import tmbe_pkg::*;

	localparam int PTR_W = $clog2(TAPE_DEPTH);
	localparam int PC_W  = $clog2(PROG_DEPTH);
	localparam int TW    = PTR_W + 1;
	localparam int PW    = PC_W + 1;
	localparam int PCX   = (PC_W > NPC_W) ? PC_W : NPC_W;
	localparam int SHW   = 40;
	localparam logic [TW-1:0] T_D = TW'(TAPE_DEPTH);
	localparam logic [PW-1:0] P_D = PW'(PROG_DEPTH);
	localparam bit T_POW2 = (TAPE_DEPTH & (TAPE_DEPTH - 1)) == 0;
	localparam bit P_POW2 = (PROG_DEPTH & (PROG_DEPTH - 1)) == 0;
	localparam int RED_N  = max_int(red_steps(TAPE_DEPTH), red_steps(PROG_DEPTH));
	localparam bit RED_ON = RED_N > 0;
	localparam logic [RED_K_W-1:0] K_INIT = RED_K_W'((RED_N > 0) ? (RED_N - 1) : 0);
	localparam logic [PTR_W-1:0] T_LAST = PTR_W'(TAPE_DEPTH - 1);

	function automatic logic [PTR_W-1:0] t_wrap(logic [PTR_W-1:0] b, logic n,
			logic [MAG_W-1:0] m);
		logic [TW-1:0] mm;
		logic [TW-1:0] ad;
		logic [TW-1:0] sum;
		mm = TW'(m);
		ad = n ? (T_D - mm) : mm;
		sum = TW'(b) + ad;
		if (sum >= T_D)
			sum = sum - T_D;
		return sum[PTR_W-1:0];
	endfunction

	function automatic logic [PC_W-1:0] p_wrap(logic [PC_W-1:0] b, logic n,
			logic [MAG_W-1:0] m);
		logic [PW-1:0] mm;
		logic [PW-1:0] ad;
		logic [PW-1:0] sum;
		mm = PW'(m);
		ad = n ? (P_D - mm) : mm;
		sum = PW'(b) + ad;
		if (sum >= P_D)
			sum = sum - P_D;
		return sum[PC_W-1:0];
	endfunction

	function automatic logic [PC_W-1:0] p_inc(logic [PC_W-1:0] b);
		logic [PW-1:0] s;
		s = PW'(b) + PW'(1);
		if (s == P_D)
			s = '0;
		return s[PC_W-1:0];
	endfunction

	// architectural and control registers
	logic [PTR_W-1:0]  dp_q;
	logic [PC_W-1:0]   pc_q;
	logic [PTR_W-1:0]  clr_q;
	logic              res_full_q;

	// latched instruction and working registers
	logic [MODE_W-1:0]  op_q;
	logic [BYTE_W-1:0]  val_q;
	logic               neg_q;
	logic [BYTE_W-1:0]  byte_q;
	logic               eof_q;
	logic [MAG_W-1:0]   mt_q;
	logic [MAG_W-1:0]   mp_q;
	logic [RED_K_W-1:0] k_q;
	logic [PTR_W-1:0]   p_q;
	logic [PTR_W-1:0]   cnt_q;
	logic [PTR_W-1:0]   dst_q;
	logic [BYTE_W-1:0]  prod_q;

	// result register
	logic [NPC_W-1:0]   res_pc_q;
	logic               res_ov_q;
	logic [BYTE_W-1:0]  res_ob_q;
	logic [STAT_W-1:0]  res_st_q;

	logic [MAG_W-1:0]   raw_in;
	logic [MAG_W-1:0]   mag_in;
	logic [MAG_W-1:0]   mt_ld;
	logic [MAG_W-1:0]   mp_ld;
	logic [SHW-1:0]     t_sh;
	logic [SHW-1:0]     p_sh;
	logic [BYTE_W-1:0]  rd_byte;
	logic [PTR_W-1:0]   dst_c;
	logic [PTR_W-1:0]   p_nxt;
	logic [PC_W-1:0]    jmp_pc;
	logic [2*BYTE_W-1:0] prod_c;

	logic [PC_W-1:0]    npc_c;
	logic [PCX-1:0]     npc_x;
	logic [STAT_W-1:0]  stat_c;
	logic               ov_c;
	logic [BYTE_W-1:0]  ob_c;
	logic [PTR_W-1:0]   dp_c;
	logic               we_f;
	logic [PTR_W-1:0]   wa_f;
	logic [BYTE_W-1:0]  wd_f;

	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr;
	logic [BYTE_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [PTR_W-1:0]   ram_raddr;

	// offset magnitude, pre-masked where the depth is a power of two
	assign raw_in = offset;
	assign mag_in = raw_in[OFS_W-1] ? (MAG_W'(0) - raw_in) : raw_in;
	assign mt_ld  = T_POW2 ? (mag_in & MAG_W'(TAPE_DEPTH - 1)) : mag_in;
	assign mp_ld  = P_POW2 ? (mag_in & MAG_W'(PROG_DEPTH - 1)) : mag_in;
	assign t_sh   = SHW'(TAPE_DEPTH) << k_q;
	assign p_sh   = SHW'(PROG_DEPTH) << k_q;

	assign dst_c  = t_wrap(dp_q, neg_q, mt_q);
	assign p_nxt  = t_wrap(p_q, neg_q, mt_q);
	assign jmp_pc = p_inc(p_wrap(pc_q, neg_q, mp_q));
	assign prod_c = rd_byte * val_q;

	always_comb begin
		npc_c = p_inc(pc_q);
		stat_c = ST_OK;
		ov_c = 1'b0;
		ob_c = '0;
		dp_c = dp_q;
		we_f = 1'b0;
		wa_f = dp_q;
		wd_f = rd_byte;
		unique case (op_q)
			OP_ADD: begin
				we_f = 1'b1;
				wd_f = rd_byte + val_q;
			end
			OP_SET: begin
				we_f = 1'b1;
				wd_f = val_q;
			end
			OP_MUL: begin
				we_f = 1'b1;
				wa_f = dst_q;
				wd_f = rd_byte + prod_q;
			end
			OP_SCAN: begin
				if (rd_byte == '0) begin
					dp_c = p_q;
				end else begin
					stat_c = ST_NOZERO;
					npc_c = pc_q;
				end
			end
			OP_MOVE: begin
				dp_c = dst_c;
			end
			OP_JZ: begin
				if (rd_byte == '0)
					npc_c = jmp_pc;
			end
			OP_JNZ: begin
				if (rd_byte != '0)
					npc_c = jmp_pc;
			end
			OP_IO: begin
				if (val_q == '0) begin
					we_f = 1'b1;
					wd_f = eof_q ? '0 : byte_q;
				end else begin
					ov_c = 1'b1;
					ob_c = rd_byte;
				end
			end
			OP_HALT: begin
				stat_c = ST_HALT;
				npc_c = pc_q;
			end
			OP_EMPTY: begin
				stat_c = ST_EMPTY;
				npc_c = pc_q;
			end
			default: begin
				stat_c = ST_BADOP;
				npc_c = pc_q;
			end
		endcase
	end

	assign npc_x = PCX'(npc_c);

	// tape port muxing
	assign ram_we    = cmd.clr_step | (cmd.finish & we_f);
	assign ram_waddr = cmd.clr_step ? clr_q : wa_f;
	assign ram_wdata = cmd.clr_step ? '0 : wd_f;
	assign ram_re    = cmd.take | cmd.mul_rd | cmd.scan_step;

	always_comb begin
		priority if (cmd.take)
			ram_raddr = dp_q;
		else if (cmd.mul_rd)
			ram_raddr = dst_c;
		else
			ram_raddr = p_nxt;
	end

	tmbe_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(TAPE_DEPTH)
	) u_tape (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_q <= '0;
			pc_q <= '0;
			clr_q <= '0;
			res_full_q <= 1'b0;
		end else begin
			if (cmd.clr_step)
				clr_q <= clr_q + PTR_W'(1);
			if (cmd.finish) begin
				dp_q <= dp_c;
				pc_q <= npc_c;
			end
			if (cmd.finish)
				res_full_q <= 1'b1;
			else if (!result_stall)
				res_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q <= mode;
			val_q <= value;
			neg_q <= raw_in[OFS_W-1];
			byte_q <= in_byte;
			eof_q <= in_eof;
			mt_q <= mt_ld;
			mp_q <= mp_ld;
			k_q <= K_INIT;
			p_q <= dp_q;
			cnt_q <= '0;
		end
		if (cmd.red_step) begin
			if (SHW'(mt_q) >= t_sh)
				mt_q <= mt_q - t_sh[MAG_W-1:0];
			if (SHW'(mp_q) >= p_sh)
				mp_q <= mp_q - p_sh[MAG_W-1:0];
			k_q <= k_q - RED_K_W'(1);
		end
		if (cmd.scan_step) begin
			p_q <= p_nxt;
			cnt_q <= cnt_q + PTR_W'(1);
		end
		if (cmd.mul_rd) begin
			dst_q <= dst_c;
			prod_q <= prod_c[BYTE_W-1:0];
		end
		if (cmd.finish) begin
			res_pc_q <= npc_x[NPC_W-1:0];
			res_ov_q <= ov_c;
			res_ob_q <= ob_c;
			res_st_q <= stat_c;
		end
	end

	assign st.in_red   = RED_ON && (mode == OP_MUL || mode == OP_SCAN || mode == OP_MOVE ||
		mode == OP_JZ || mode == OP_JNZ);
	assign st.red_last = k_q == '0;
	assign st.clr_last = clr_q == T_LAST;
	assign st.op_mul   = op_q == OP_MUL;
	assign st.op_scan  = op_q == OP_SCAN;
	assign st.scan_end = (rd_byte == '0) || (cnt_q == T_LAST);
	assign st.slot_ok  = !res_full_q || !result_stall;

	assign result_valid = res_full_q;
	assign next_pc      = res_pc_q;
	assign out_valid    = res_ov_q;
	assign out_byte     = res_ob_q;
	assign status       = res_st_q;

endmodule

[test/tb_tape_machine_bitcode_executor_top.sv]
// testbench for tape_machine_bitcode_executor_top: directed and random instruction streams
// against a behavioural copy of the tape machine, with random issue gaps and result stalls
// depends on tmbe_pkg and the executor rtl
module tb_tape_machine_bitcode_executor_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tmbe_pkg::*;

	localparam int TAPE_CELLS = TAPE_DEPTH_DEF;
	localparam int PROG_WORDS = PROG_DEPTH_DEF;
	localparam logic [MODE_W-1:0] OP_BAD_LO = 4'd10;
	localparam logic [MODE_W-1:0] OP_BAD_HI = 4'd15;
	localparam int STALL_LIMIT = 4 * (TAPE_CELLS + 200);
	localparam int HOLD_CYCLES = 80;
	localparam int MAX_PRINTS = 60;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] value;
		logic signed [OFS_W-1:0] offset;
		logic [BYTE_W-1:0] in_byte;
		logic in_eof;
	} instr_t;

	typedef struct {
		logic [NPC_W-1:0] npc;
		logic ovalid;
		logic [BYTE_W-1:0] obyte;
		logic [STAT_W-1:0] stat;
	} exec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic instr_valid = 1'b0;
	logic instr_stall;
	logic [MODE_W-1:0] mode = '0;
	logic [BYTE_W-1:0] value = '0;
	logic signed [OFS_W-1:0] offset = '0;
	logic [BYTE_W-1:0] in_byte = '0;
	logic in_eof = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [NPC_W-1:0] next_pc;
	logic out_valid;
	logic [BYTE_W-1:0] out_byte;
	logic [STAT_W-1:0] status;

	bit [BYTE_W-1:0] tape_mem [TAPE_CELLS];
	int unsigned tape_ptr = 0;
	int unsigned prog_ctr = 0;
	exec_result_t exec_results_q[$];

	bit steady = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int fail_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int byte_out_count = 0;
	int nozero_count = 0;
	int jump_taken_count = 0;
	int quiet_cycles = 0;

	tape_machine_bitcode_executor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.instr_valid(instr_valid),
		.instr_stall(instr_stall),
		.mode(mode),
		.value(value),
		.offset(offset),
		.in_byte(in_byte),
		.in_eof(in_eof),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.next_pc(next_pc),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.status(status)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int unsigned wrap_pos(int unsigned base, logic signed [OFS_W-1:0] ofs,
			int unsigned depth);
		longint r;
		r = (longint'(base) + longint'(ofs)) % longint'(depth);
		if (r < 0)
			r += depth;
		return int'(r);
	endfunction

	function automatic exec_result_t execute_instr(instr_t it);
		exec_result_t res;
		int unsigned ptr;
		int unsigned dst;
		int unsigned p;
		bit found;
		bit [BYTE_W-1:0] prod;
		ptr = tape_ptr;
		p = ptr;
		found = 0;
		res.npc = NPC_W'((prog_ctr + 1) % PROG_WORDS);
		res.ovalid = 1'b0;
		res.obyte = '0;
		res.stat = ST_OK;
		case (it.mode)
			OP_ADD: tape_mem[ptr] = tape_mem[ptr] + it.value;
			OP_SET: tape_mem[ptr] = it.value;
			OP_MUL: begin
				dst = wrap_pos(ptr, it.offset, TAPE_CELLS);
				prod = tape_mem[ptr] * it.value;
				tape_mem[dst] = tape_mem[dst] + prod;
			end
			OP_SCAN: begin
				for (int n = 0; n < TAPE_CELLS && !found; n++) begin
					if (tape_mem[p] == 0)
						found = 1;
					else
						p = wrap_pos(p, it.offset, TAPE_CELLS);
				end
				if (found) begin
					ptr = p;
				end else begin
					res.stat = ST_NOZERO;
					res.npc = NPC_W'(prog_ctr);
					nozero_count++;
				end
			end
			OP_MOVE: ptr = wrap_pos(ptr, it.offset, TAPE_CELLS);
			OP_JZ, OP_JNZ: begin
				if ((it.mode == OP_JZ) == (tape_mem[ptr] == 0)) begin
					res.npc = NPC_W'((wrap_pos(prog_ctr, it.offset, PROG_WORDS) + 1) % PROG_WORDS);
					jump_taken_count++;
				end
			end
			OP_IO: begin
				if (it.value == 0) begin
					tape_mem[ptr] = it.in_eof ? '0 : it.in_byte;
				end else begin
					res.ovalid = 1'b1;
					res.obyte = tape_mem[ptr];
				end
			end
			OP_HALT: begin
				res.stat = ST_HALT;
				res.npc = NPC_W'(prog_ctr);
			end
			OP_EMPTY: begin
				res.stat = ST_EMPTY;
				res.npc = NPC_W'(prog_ctr);
			end
			default: begin
				res.stat = ST_BADOP;
				res.npc = NPC_W'(prog_ctr);
			end
		endcase
		tape_ptr = ptr;
		prog_ctr = res.npc;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)", $realtime, what,
				got, want, checked_count);
	endtask

	// prediction on accepted instructions, checking on accepted results, watchdog
	always @(posedge clk) begin : monitor
		exec_result_t want;
		bit moved;
		if (arst_n) begin
			moved = 0;
			if (result_valid && !result_stall) begin
				moved = 1;
				if (exec_results_q.size() == 0) begin
					report_mismatch("result with nothing pending", next_pc, 0);
				end else begin
					want = exec_results_q.pop_front();
					if (next_pc !== want.npc)
						report_mismatch("next_pc", next_pc, want.npc);
					if (out_valid !== want.ovalid)
						report_mismatch("out_valid", out_valid, want.ovalid);
					if (out_byte !== want.obyte)
						report_mismatch("out_byte", out_byte, want.obyte);
					if (status !== want.stat)
						report_mismatch("status", status, want.stat);
					if (want.ovalid)
						byte_out_count++;
				end
				checked_count++;
			end
			if (instr_valid && !instr_stall) begin
				instr_t it;
				moved = 1;
				it.mode = mode;
				it.value = value;
				it.offset = offset;
				it.in_byte = in_byte;
				it.in_eof = in_eof;
				exec_results_q.insert(exec_results_q.size(), execute_instr(it));
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[%0t] no transaction for %0d cycles", $realtime, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: random stalls plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 0;
			hold_left = HOLD_CYCLES - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !steady && ($urandom_range(0, 99) < 8);
		end
	end

	task automatic issue_instr(input instr_t it);
		bit placed;
		placed = 0;
		while (!placed) begin
			@(negedge clk);
			if (!steady && $urandom_range(0, 99) < 8) begin
				instr_valid <= 1'b0;
			end else begin
				mode <= it.mode;
				value <= it.value;
				offset <= it.offset;
				in_byte <= it.in_byte;
				in_eof <= it.in_eof;
				instr_valid <= 1'b1;
				placed = 1;
			end
		end
		do
			@(posedge clk);
		while (!(instr_valid && !instr_stall));
		sent_count++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		instr_valid <= 1'b0;
		while (exec_results_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic instr_t mk(logic [MODE_W-1:0] op, int val, int ofs, int ib = 0,
			bit eof = 0);
		instr_t it;
		it.mode = op;
		it.value = BYTE_W'(val);
		it.offset = OFS_W'(ofs);
		it.in_byte = BYTE_W'(ib);
		it.in_eof = eof;
		return it;
	endfunction

	function automatic instr_t rand_instr();
		instr_t it;
		int pick;
		int near;
		pick = $urandom_range(0, 99);
		near = int'($urandom_range(0, 16)) - 8;
		it.value = BYTE_W'($urandom_range(0, 255));
		it.in_byte = BYTE_W'($urandom_range(0, 255));
		it.in_eof = ($urandom_range(0, 4) == 0);
		it.offset = ($urandom_range(0, 3) == 0) ? OFS_W'($urandom) : OFS_W'(near);
		if (pick < 12) begin
			it.mode = OP_ADD;
		end else if (pick < 22) begin
			it.mode = OP_SET;
			if ($urandom_range(0, 9) < 3)
				it.value = '0;
		end else if (pick < 34) begin
			it.mode = OP_MUL;
		end else if (pick < 44) begin
			it.mode = OP_SCAN;
			if (it.offset == 0)
				it.offset = 1;
		end else if (pick < 58) begin
			it.mode = OP_MOVE;
			if ($urandom_range(0, 9) != 0)
				it.offset = OFS_W'(near);
		end else if (pick < 66) begin
			it.mode = OP_JZ;
		end else if (pick < 74) begin
			it.mode = OP_JNZ;
		end else if (pick < 86) begin
			it.mode = OP_IO;
			if ($urandom_range(0, 1) == 0)
				it.value = '0;
		end else if (pick < 90) begin
			it.mode = OP_HALT;
		end else if (pick < 94) begin
			it.mode = OP_EMPTY;
		end else begin
			it.mode = MODE_W'($urandom_range(OP_BAD_LO, OP_BAD_HI));
		end
		return it;
	endfunction

	// arithmetic wrap, self-targeted multiply, pointer and counter wrap, io with end of input
	task automatic test_directed_ops();
		issue_instr(mk(OP_EMPTY, 0, 0));
		issue_instr(mk(OP_BAD_LO, 255, -1, 255, 1));
		issue_instr(mk(OP_BAD_HI, 0, 0));
		issue_instr(mk(OP_SET, 255, 0));
		issue_instr(mk(OP_ADD, 1, 0));
		issue_instr(mk(OP_ADD, 200, 0));
		issue_instr(mk(OP_MUL, 3, 1));
		issue_instr(mk(OP_MUL, 2, 0));
		issue_instr(mk(OP_MUL, 1, -65536));
		issue_instr(mk(OP_MOVE, 0, 65535));
		issue_instr(mk(OP_MOVE, 0, 1));
		issue_instr(mk(OP_JNZ, 0, 65535));
		issue_instr(mk(OP_JZ, 0, -2));
		issue_instr(mk(OP_IO, 0, 0, 255, 0));
		issue_instr(mk(OP_IO, 1, 0));
		issue_instr(mk(OP_IO, 0, 0, 170, 1));
		issue_instr(mk(OP_JZ, 0, -65536));
		issue_instr(mk(OP_IO, 255, 0));
		issue_instr(mk(OP_HALT, 255, 65535));
		issue_instr(mk(OP_SCAN, 0, 1));
		drain_results();
	endtask

	// scans that find a zero and scans that give up after a full sweep
	task automatic test_scan_endings();
		issue_instr(mk(OP_SET, 7, 0));
		issue_instr(mk(OP_MOVE, 0, 1));
		issue_instr(mk(OP_SET, 9, 0));
		issue_instr(mk(OP_SCAN, 0, -1));
		issue_instr(mk(OP_SET, 3, 0));
		issue_instr(mk(OP_SCAN, 0, 0));
		issue_instr(mk(OP_MOVE, 0, 16384));
		issue_instr(mk(OP_SET, 6, 0));
		issue_instr(mk(OP_SCAN, 0, -16384));
		issue_instr(mk(OP_SET, 0, 0));
		issue_instr(mk(OP_MOVE, 0, 16384));
		issue_instr(mk(OP_SCAN, 0, 16384));
		drain_results();
	endtask

	task automatic test_random_programs(input int count);
		repeat (count)
			issue_instr(rand_instr());
	endtask

	task automatic test_steady_stream(input int count);
		steady = 1;
		repeat (count)
			issue_instr(rand_instr());
		steady = 0;
	endtask

	// result side held off while instructions keep coming, then a full drain
	task automatic test_backpressure(input int count);
		hold_req = 1;
		repeat (count)
			issue_instr(rand_instr());
		drain_results();
	endtask

	initial begin
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_ops();
		test_scan_endings();
		test_random_programs(500);
		test_steady_stream(200);
		test_backpressure(40);
		test_random_programs(640);
		drain_results();
		repeat (20)
			@(posedge clk);
		if (exec_results_q.size() != 0)
			report_mismatch("results never delivered", 0, exec_results_q.size());
		$display("run: %0d instructions, %0d results compared, %0d mismatches", sent_count,
			checked_count, fail_count);
		$display("run: %0d output bytes, %0d taken jumps, %0d scans without a zero cell",
			byte_out_count, jump_taken_count, nozero_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[tape_machine_bitcode_executor_top.f]
+incdir+hw/rtl
hw/rtl/tmbe_pkg.sv
hw/rtl/tmbe_ram.sv
hw/rtl/tmbe_ctrl.sv
hw/rtl/tmbe_dp.sv
hw/rtl/tape_machine_bitcode_executor_top.sv
test/tb_tape_machine_bitcode_executor_top.sv
